// ----- rtl/rht_pkg.sv -----
package rht_pkg;

  localparam int CMD_W    = 3;
  localparam int TASK_W   = 4;
  localparam int SLOT_W   = 6;
  localparam int FLAG_W   = 8;
  localparam int HANDLE_W = 7;
  localparam int STATUS_W = 2;
  localparam int REFS_W   = 10;

  localparam logic [SLOT_W-1:0] FIRST_USER_SLOT = SLOT_W'(3);
  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT      = 3'd0,
    CMD_ALLOC     = 3'd1,
    CMD_FREE      = 3'd2,
    CMD_GET       = 3'd3,
    CMD_GET_FLAGS = 3'd4,
    CMD_SET_FLAGS = 3'd5,
    CMD_DUP       = 3'd6,
    CMD_DUP2      = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD       = 2'd1,
    STAT_NO_SLOT   = 2'd2,
    STAT_POOL_FULL = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TASK_W-1:0] task_id;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] second_slot;
    logic [FLAG_W-1:0] flag_value;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [FLAG_W-1:0]   flags_out;
    logic                released;
    logic [HANDLE_W-1:0] released_handle;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [FLAG_W-1:0]   flags;
  } slot_entry_t;

endpackage

// ----- rtl/rht_ram.sv -----
module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rht_find.sv -----
// Two-stage lowest-set-bit finder: byte groups first, then the first group.
module rht_find #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic [W-1:0]         vec,
  output logic                 found,
  output logic [$clog2(W)-1:0] idx
);

  localparam int NG = (W + 7) / 8;
  localparam int PW = NG * 8;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int IW = $clog2(W);

  logic [PW-1:0] pad;
  logic [NG-1:0] g_any;
  logic [2:0]    g_idx [NG];
  logic          sel_any;
  logic [GW+2:0] sel;

  function automatic logic [2:0] first8(input logic [7:0] b);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  assign pad = PW'(vec);

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      g_any[g] <= |pad[g*8 +: 8];
      g_idx[g] <= first8(pad[g*8 +: 8]);
    end
  end

  always_comb begin
    sel_any = 1'b0;
    sel     = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (g_any[g]) begin
        sel_any = 1'b1;
        sel     = {GW'(g), g_idx[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    found <= sel_any;
    idx   <= IW'(sel);
  end

endmodule

// ----- rtl/refcounted_handle_table.sv -----
// Each accepted request passes the slot memory read and the two-stage free finders before
// done; free, dup and dup2 may add a refcount read-modify-write, and init binds a fresh
// handle to slots 0 to 2 in turn. A new request may be taken in the cycle done is high.
// Synchronous active-high reset empties every slot and the whole handle pool at once.
// Each result shows for exactly one cycle with done; the receiver cannot stall it.
module refcounted_handle_table #(
  parameter int SLOTS_PER_TASK = 32,
  parameter int POOL_HANDLES   = 128,
  parameter int TASK_COUNT     = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rht_pkg::req_t req,
  output logic          done,
  output rht_pkg::rsp_t rsp
);

  localparam int SPT   = SLOTS_PER_TASK;
  localparam int SW    = $clog2(SPT);
  localparam int HW    = $clog2(POOL_HANDLES);
  localparam int TW    = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int DEPTH = TASK_COUNT * SPT;
  localparam int AW    = $clog2(DEPTH);
  localparam int HDW   = rht_pkg::HANDLE_W;
  localparam int RW    = rht_pkg::REFS_W;
  localparam int SLW   = rht_pkg::SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_EXEC, S_INIT, S_INITW0, S_INITW1,
    S_TRD, S_TGET, S_BIND2, S_REFRD, S_REFOP
  } state_t;

  state_t              state;
  state_t              ret;
  rht_pkg::req_t       rq;
  rht_pkg::rsp_t       res;
  logic [SPT-1:0]      row_valid [TASK_COUNT];
  logic [POOL_HANDLES-1:0] hv;
  logic [1:0]          ic;
  logic [HDW-1:0]      hop_h;
  logic                hop_add;
  logic [HDW-1:0]      hsrc;

  // Registered write ports of both memories
  logic                 sw_en;
  logic [AW-1:0]        sw_addr;
  rht_pkg::slot_entry_t sw_data;
  logic                 rw_en;
  logic [HW-1:0]        rw_addr;
  logic [RW-1:0]        rw_data;

  logic [AW-1:0]        slot_raddr;
  rht_pkg::slot_entry_t sdat;
  logic [RW-1:0]        rdat;

  logic [TW-1:0]   tidx;
  logic            task_ok;
  logic [SPT-1:0]  row;
  logic            s_ok;
  logic            t_in;
  logic [SLW-1:0]  lo;
  logic [SPT-1:0]  slot_free;
  logic [AW-1:0]   addr_s;
  logic [AW-1:0]   addr_t;
  logic [AW-1:0]   addr_i;
  logic [AW-1:0]   addr_f;
  logic            sd_live;
  logic            hop_live;
  logic [RW-1:0]   refs_next;

  logic            sf_found;
  logic [SW-1:0]   sf_idx;
  logic            hf_found;
  logic [HW-1:0]   hf_idx;

  assign busy = (state != S_IDLE);
  assign rsp  = res;

  // Decode the held request against the task's valid row
  always_comb begin
    tidx    = rq.task_id[TW-1:0];
    task_ok = {1'b0, rq.task_id} < (rht_pkg::TASK_W + 1)'(TASK_COUNT);
    row     = task_ok ? row_valid[tidx] : '0;
    s_ok    = ({1'b0, rq.slot} < (SLW + 1)'(SPT)) && row[rq.slot[SW-1:0]];
    t_in    = {1'b0, rq.second_slot} < (SLW + 1)'(SPT);
    if (rq.cmd == rht_pkg::CMD_DUP && rq.second_slot > rht_pkg::FIRST_USER_SLOT) begin
      lo = rq.second_slot;
    end else begin
      lo = rht_pkg::FIRST_USER_SLOT;
    end
    for (int i = 0; i < SPT; i++) begin
      slot_free[i] = !row[i] && (SLW'(i) >= lo);
    end
    addr_s = AW'(rq.task_id) * AW'(SPT) + AW'(rq.slot);
    addr_t = AW'(rq.task_id) * AW'(SPT) + AW'(rq.second_slot);
    addr_i = AW'(rq.task_id) * AW'(SPT) + AW'(ic);
    addr_f = AW'(rq.task_id) * AW'(SPT) + AW'(sf_idx);
    slot_raddr = (state == S_TRD) ? addr_t : addr_s;
    sd_live  = ({1'b0, sdat.handle} < (HDW + 1)'(POOL_HANDLES)) && hv[sdat.handle[HW-1:0]];
    hop_live = ({1'b0, hop_h} < (HDW + 1)'(POOL_HANDLES)) && hv[hop_h[HW-1:0]];
    // Saturating count step for add, floor at zero for drop
    if (hop_add) begin
      refs_next = (rdat < rht_pkg::REFS_MAX) ? rdat + RW'(1) : rdat;
    end else begin
      refs_next = (rdat != '0) ? rdat - RW'(1) : '0;
    end
  end

  rht_ram #(.WIDTH($bits(rht_pkg::slot_entry_t)), .DEPTH(DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (sw_en),
    .waddr (sw_addr),
    .wdata (sw_data),
    .raddr (slot_raddr),
    .rdata (sdat)
  );

  rht_ram #(.WIDTH(RW), .DEPTH(POOL_HANDLES)) u_refs_ram (
    .clk   (clk),
    .we    (rw_en),
    .waddr (rw_addr),
    .wdata (rw_data),
    .raddr (hop_h[HW-1:0]),
    .rdata (rdat)
  );

  rht_find #(.W(SPT)) u_slot_find (
    .clk   (clk),
    .vec   (slot_free),
    .found (sf_found),
    .idx   (sf_idx)
  );

  rht_find #(.W(POOL_HANDLES)) u_handle_find (
    .clk   (clk),
    .vec   (~hv),
    .found (hf_found),
    .idx   (hf_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      sw_en <= 1'b0;
      rw_en <= 1'b0;
      hv    <= '0;
      for (int t = 0; t < TASK_COUNT; t++) begin
        row_valid[t] <= '0;
      end
    end else begin
      done  <= 1'b0;
      sw_en <= 1'b0;
      rw_en <= 1'b0;
      unique case (state)
        S_IDLE: begin
          // Take a new request, clear the result fields
          if (start) begin
            rq    <= req;
            res   <= '0;
            state <= S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          // Slot entry and finder results are ready next cycle
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (!task_ok) begin
            res.status <= rht_pkg::STAT_BAD;
            state      <= S_IDLE;
            done       <= 1'b1;
          end else begin
            unique case (rq.cmd)
              rht_pkg::CMD_INIT: begin
                // Drop the whole row without touching references
                row_valid[tidx] <= '0;
                ic              <= '0;
                state           <= S_INIT;
              end
              rht_pkg::CMD_ALLOC: begin
                state <= S_IDLE;
                done  <= 1'b1;
                if (!sf_found) begin
                  res.status <= rht_pkg::STAT_NO_SLOT;
                end else if (!hf_found) begin
                  res.status <= rht_pkg::STAT_POOL_FULL;
                end else begin
                  hv[hf_idx]              <= 1'b1;
                  rw_en                   <= 1'b1;
                  rw_addr                 <= hf_idx;
                  rw_data                 <= RW'(1);
                  sw_en                   <= 1'b1;
                  sw_addr                 <= addr_f;
                  sw_data.handle          <= HDW'(hf_idx);
                  sw_data.flags           <= '0;
                  row_valid[tidx][sf_idx] <= 1'b1;
                  res.slot_out            <= SLW'(sf_idx);
                  res.handle_out          <= HDW'(hf_idx);
                end
              end
              rht_pkg::CMD_FREE: begin
                if (!s_ok) begin
                  res.status <= rht_pkg::STAT_BAD;
                  state      <= S_IDLE;
                  done       <= 1'b1;
                end else begin
                  row_valid[tidx][rq.slot[SW-1:0]] <= 1'b0;
                  hop_h   <= sdat.handle;
                  hop_add <= 1'b0;
                  ret     <= S_IDLE;
                  state   <= S_REFRD;
                end
              end
              rht_pkg::CMD_GET: begin
                state <= S_IDLE;
                done  <= 1'b1;
                if (!s_ok || !sd_live) begin
                  res.status <= rht_pkg::STAT_BAD;
                end else begin
                  res.handle_out <= sdat.handle;
                end
              end
              rht_pkg::CMD_GET_FLAGS: begin
                state <= S_IDLE;
                done  <= 1'b1;
                if (!s_ok) begin
                  res.status <= rht_pkg::STAT_BAD;
                end else begin
                  res.flags_out <= sdat.flags;
                end
              end
              rht_pkg::CMD_SET_FLAGS: begin
                state <= S_IDLE;
                done  <= 1'b1;
                if (!s_ok) begin
                  res.status <= rht_pkg::STAT_BAD;
                end else begin
                  sw_en          <= 1'b1;
                  sw_addr        <= addr_s;
                  sw_data.handle <= sdat.handle;
                  sw_data.flags  <= rq.flag_value;
                end
              end
              rht_pkg::CMD_DUP: begin
                if (!s_ok || !sf_found) begin
                  res.status <= s_ok ? rht_pkg::STAT_NO_SLOT : rht_pkg::STAT_BAD;
                  state      <= S_IDLE;
                  done       <= 1'b1;
                end else begin
                  row_valid[tidx][sf_idx] <= 1'b1;
                  sw_en          <= 1'b1;
                  sw_addr        <= addr_f;
                  sw_data.handle <= sdat.handle;
                  sw_data.flags  <= '0;
                  res.slot_out   <= SLW'(sf_idx);
                  hop_h          <= sdat.handle;
                  hop_add        <= 1'b1;
                  ret            <= S_IDLE;
                  state          <= S_REFRD;
                end
              end
              rht_pkg::CMD_DUP2: begin
                if (!s_ok || !t_in) begin
                  res.status <= rht_pkg::STAT_BAD;
                  state      <= S_IDLE;
                  done       <= 1'b1;
                end else begin
                  res.slot_out <= rq.second_slot;
                  hsrc         <= sdat.handle;
                  if (rq.second_slot == rq.slot) begin
                    state <= S_IDLE;
                    done  <= 1'b1;
                  end else if (row[rq.second_slot[SW-1:0]]) begin
                    state <= S_TRD;
                  end else begin
                    state <= S_BIND2;
                  end
                end
              end
              default: begin
                state <= S_IDLE;
                done  <= 1'b1;
              end
            endcase
          end
        end
        S_INIT: begin
          // Give slot ic a fresh handle, or report the pool full
          if (hf_found) begin
            hv[hf_idx]            <= 1'b1;
            rw_en                 <= 1'b1;
            rw_addr               <= hf_idx;
            rw_data               <= RW'(1);
            sw_en                 <= 1'b1;
            sw_addr               <= addr_i;
            sw_data.handle        <= HDW'(hf_idx);
            sw_data.flags         <= '0;
            row_valid[tidx][SW'(ic)] <= 1'b1;
          end else begin
            res.status <= rht_pkg::STAT_POOL_FULL;
          end
          if (ic == 2'd2) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            ic    <= ic + 2'd1;
            state <= S_INITW0;
          end
        end
        S_INITW0: begin
          state <= S_INITW1;
        end
        S_INITW1: begin
          // Handle finder output reflects the last grab once back in S_INIT
          state <= S_INIT;
        end
        S_TRD: begin
          state <= S_TGET;
        end
        S_TGET: begin
          // Close the dup2 target, dropping its reference, then bind it
          row_valid[tidx][rq.second_slot[SW-1:0]] <= 1'b0;
          hop_h   <= sdat.handle;
          hop_add <= 1'b0;
          ret     <= S_BIND2;
          state   <= S_REFRD;
        end
        S_BIND2: begin
          row_valid[tidx][rq.second_slot[SW-1:0]] <= 1'b1;
          sw_en          <= 1'b1;
          sw_addr        <= addr_t;
          sw_data.handle <= hsrc;
          sw_data.flags  <= '0;
          hop_h          <= hsrc;
          hop_add        <= 1'b1;
          ret            <= S_IDLE;
          state          <= S_REFRD;
        end
        S_REFRD: begin
          // Skip stale handles; otherwise the count arrives next cycle
          if (hop_live) begin
            state <= S_REFOP;
          end else begin
            state <= ret;
            done  <= (ret == S_IDLE);
          end
        end
        S_REFOP: begin
          rw_en   <= 1'b1;
          rw_addr <= hop_h[HW-1:0];
          rw_data <= refs_next;
          if (!hop_add && refs_next == '0) begin
            hv[hop_h[HW-1:0]]   <= 1'b0;
            res.released        <= 1'b1;
            res.released_handle <= hop_h;
          end
          state <= ret;
          done  <= (ret == S_IDLE);
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- bench/refcounted_handle_table_tb.sv -----
module refcounted_handle_table_tb;

  localparam int SLOTS  = 32;
  localparam int POOL   = 128;
  localparam int TASKS  = 16;
  localparam int REFCAP = 1023;
  localparam int CYCLE_LIMIT = 400000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  rht_pkg::req_t  req = '0;
  logic  done;
  rht_pkg::rsp_t  rsp;

  refcounted_handle_table dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the slot tables and the handle pool, kept by the predictor.
  bit            sh_slot_live [TASKS*SLOTS];
  logic [6:0]    sh_slot_hdl  [TASKS*SLOTS];
  logic [7:0]    sh_slot_flg  [TASKS*SLOTS];
  bit            sh_hdl_live  [POOL];
  int unsigned   sh_hdl_refs  [POOL];

  rht_pkg::req_t   pending_reqs[$];
  rht_pkg::rsp_t   expected_rsps[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  int     idle_left = 0;
  bit     idle_enable = 1'b1;
  bit     hold_until_drained = 1'b0;

  // Result of the current step's release bookkeeping.
  bit         rel_seen;
  logic [6:0] rel_hdl;

  function automatic int grab_handle();
    for (int h = 0; h < POOL; h++) begin
      if (!sh_hdl_live[h]) begin
        sh_hdl_live[h] = 1'b1;
        sh_hdl_refs[h] = 1;
        return h;
      end
    end
    return -1;
  endfunction

  function automatic void add_ref(int unsigned h);
    if (h >= POOL || !sh_hdl_live[h]) return;
    if (sh_hdl_refs[h] < REFCAP) sh_hdl_refs[h]++;
  endfunction

  function automatic void drop_ref(int unsigned h);
    if (h >= POOL || !sh_hdl_live[h]) return;
    if (sh_hdl_refs[h] > 0) sh_hdl_refs[h]--;
    if (sh_hdl_refs[h] > 0) return;
    sh_hdl_live[h] = 1'b0;
    rel_seen = 1'b1;
    rel_hdl = h[6:0];
  endfunction

  function automatic void close_slot(int idx);
    sh_slot_live[idx] = 1'b0;
    sh_slot_flg[idx] = '0;
    drop_ref(sh_slot_hdl[idx]);
  endfunction

  // Compute the response for one accepted request and advance the shadow.
  function automatic rht_pkg::rsp_t predict_table_op(rht_pkg::req_t r);
    rht_pkg::rsp_t o;
    int   base;
    int   i;
    int   h;
    bit   src_ok;
    o = '0;
    o.status = rht_pkg::STAT_OK;
    rel_seen = 1'b0;
    rel_hdl = '0;
    if (r.task_id >= TASKS) begin
      o.status = rht_pkg::STAT_BAD;
      return o;
    end
    base = r.task_id * SLOTS;
    src_ok = (r.slot < SLOTS) && sh_slot_live[base + r.slot];
    case (r.cmd)
      rht_pkg::CMD_INIT: begin
        for (i = 0; i < SLOTS; i++) begin
          sh_slot_live[base+i] = 1'b0;
          sh_slot_flg[base+i] = '0;
        end
        for (i = 0; i < rht_pkg::FIRST_USER_SLOT; i++) begin
          h = grab_handle();
          if (h < 0) begin
            o.status = rht_pkg::STAT_POOL_FULL;
          end else begin
            sh_slot_live[base+i] = 1'b1;
            sh_slot_hdl[base+i] = h[6:0];
          end
        end
      end
      rht_pkg::CMD_ALLOC: begin
        for (i = rht_pkg::FIRST_USER_SLOT; i < SLOTS; i++)
          if (!sh_slot_live[base+i]) break;
        if (i >= SLOTS) begin
          o.status = rht_pkg::STAT_NO_SLOT;
        end else begin
          h = grab_handle();
          if (h < 0) begin
            o.status = rht_pkg::STAT_POOL_FULL;
          end else begin
            sh_slot_live[base+i] = 1'b1;
            sh_slot_hdl[base+i] = h[6:0];
            sh_slot_flg[base+i] = '0;
            o.slot_out = i[5:0];
            o.handle_out = h[6:0];
          end
        end
      end
      rht_pkg::CMD_FREE: begin
        if (!src_ok) o.status = rht_pkg::STAT_BAD;
        else close_slot(base + r.slot);
      end
      rht_pkg::CMD_GET: begin
        if (!src_ok || !sh_hdl_live[sh_slot_hdl[base+r.slot]]) o.status = rht_pkg::STAT_BAD;
        else o.handle_out = sh_slot_hdl[base+r.slot];
      end
      rht_pkg::CMD_GET_FLAGS: begin
        if (!src_ok) o.status = rht_pkg::STAT_BAD;
        else o.flags_out = sh_slot_flg[base+r.slot];
      end
      rht_pkg::CMD_SET_FLAGS: begin
        if (!src_ok) o.status = rht_pkg::STAT_BAD;
        else sh_slot_flg[base+r.slot] = r.flag_value;
      end
      rht_pkg::CMD_DUP: begin
        if (!src_ok) begin
          o.status = rht_pkg::STAT_BAD;
        end else begin
          i = (r.second_slot < rht_pkg::FIRST_USER_SLOT) ? rht_pkg::FIRST_USER_SLOT
                                                        : r.second_slot;
          for (; i < SLOTS; i++)
            if (!sh_slot_live[base+i]) break;
          if (i >= SLOTS) begin
            o.status = rht_pkg::STAT_NO_SLOT;
          end else begin
            h = sh_slot_hdl[base+r.slot];
            sh_slot_live[base+i] = 1'b1;
            sh_slot_hdl[base+i] = h[6:0];
            sh_slot_flg[base+i] = '0;
            add_ref(h);
            o.slot_out = i[5:0];
          end
        end
      end
      default: begin
        if (!src_ok || r.second_slot >= SLOTS) begin
          o.status = rht_pkg::STAT_BAD;
        end else begin
          o.slot_out = r.second_slot;
          if (r.second_slot != r.slot) begin
            h = sh_slot_hdl[base+r.slot];
            if (sh_slot_live[base+r.second_slot]) close_slot(base + r.second_slot);
            sh_slot_live[base+r.second_slot] = 1'b1;
            sh_slot_hdl[base+r.second_slot] = h[6:0];
            sh_slot_flg[base+r.second_slot] = '0;
            add_ref(h);
          end
        end
      end
    endcase
    o.released = rel_seen;
    o.released_handle = rel_seen ? rel_hdl : '0;
    return o;
  endfunction

  function automatic rht_pkg::req_t make_req(rht_pkg::cmd_t c, int t, int s, int s2, int f);
    rht_pkg::req_t r;
    r.cmd = c;
    r.task_id = t[3:0];
    r.slot = s[5:0];
    r.second_slot = s2[5:0];
    r.flag_value = f[7:0];
    return r;
  endfunction

  // Mostly valid slots and busy tasks; some out-of-range noise.
  function automatic rht_pkg::req_t random_req();
    int t;
    int s;
    int s2;
    t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
    s2 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 14);
    return make_req(rht_pkg::cmd_t'($urandom_range(0, 7)), t, s, s2, $urandom_range(0, 255));
  endfunction

  // Driver: pop the next request when the block is free, with random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_rsps.push_back(predict_table_op(req));
        void'(pending_reqs.pop_front());
      end
      if (start && busy) begin
        // hold the request until accepted
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        idle_left <= $urandom_range(0, 3);
        start <= 1'b0;
      end else begin
        if (pending_reqs.size() > 0 &&
            !(hold_until_drained && expected_rsps.size() > 0)) begin
          start <= 1'b1;
          req <= pending_reqs[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe must match the oldest expectation.
  always @(posedge clk) begin
    rht_pkg::rsp_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response %p", rsp);
        fail_count = fail_count + 1;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status);
          fail_count = fail_count + 1;
        end
        if (rsp.slot_out !== e.slot_out) begin
          $error("slot_out exp %0d got %0d", e.slot_out, rsp.slot_out);
          fail_count = fail_count + 1;
        end
        if (rsp.handle_out !== e.handle_out) begin
          $error("handle_out exp %0d got %0d", e.handle_out, rsp.handle_out);
          fail_count = fail_count + 1;
        end
        if (rsp.flags_out !== e.flags_out) begin
          $error("flags_out exp %0d got %0d", e.flags_out, rsp.flags_out);
          fail_count = fail_count + 1;
        end
        if (rsp.released !== e.released) begin
          $error("released exp %0d got %0d", e.released, rsp.released);
          fail_count = fail_count + 1;
        end
        if (rsp.released_handle !== e.released_handle) begin
          $error("released_handle exp %0d got %0d", e.released_handle,
                 rsp.released_handle);
          fail_count = fail_count + 1;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int t;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: rejections on empty tables, then every command and edge field.
    pending_reqs.push_back(make_req(rht_pkg::CMD_GET, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_FREE, 15, 63, 63, 255));
    pending_reqs.push_back(make_req(rht_pkg::CMD_INIT, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_INIT, 15, 63, 63, 255));
    pending_reqs.push_back(make_req(rht_pkg::CMD_ALLOC, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_SET_FLAGS, 0, 3, 0, 255));
    pending_reqs.push_back(make_req(rht_pkg::CMD_GET_FLAGS, 0, 3, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_GET, 0, 3, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_DUP, 0, 3, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_DUP, 0, 3, 31, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_DUP, 0, 3, 63, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_DUP2, 0, 3, 3, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_DUP2, 0, 0, 3, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_DUP2, 0, 1, 40, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_FREE, 0, 31, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_FREE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_FREE, 0, 3, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_GET, 0, 32, 0, 0));
    pending_reqs.push_back(make_req(rht_pkg::CMD_SET_FLAGS, 0, 1, 0, 8'h55));
    pending_reqs.push_back(make_req(rht_pkg::CMD_GET_FLAGS, 0, 1, 0, 0));
    // Reinit drops slot bindings but keeps references: leaks handles.
    pending_reqs.push_back(make_req(rht_pkg::CMD_INIT, 0, 0, 0, 0));
    for (int k = 0; k < 30; k++)
      pending_reqs.push_back(make_req(rht_pkg::CMD_ALLOC, 1, 0, 0, 0));
    wait (pending_reqs.size() == 0);

    // Pause until drained before the random phase.
    hold_until_drained = 1'b1;
    wait (expected_rsps.size() == 0);
    hold_until_drained = 1'b0;

    // Exhaust the pool with inits and allocs so pool-full shows up, then run random traffic.
    for (t = 0; t < 4; t++) pending_reqs.push_back(make_req(rht_pkg::CMD_INIT, t, 0, 0, 0));
    for (int k = 0; k < 120; k++)
      pending_reqs.push_back(make_req(rht_pkg::CMD_ALLOC, $urandom_range(0, 3), 0, 0, 0));
    for (int k = 0; k < 1400; k++) pending_reqs.push_back(random_req());
    wait (pending_reqs.size() < 50);
    // Stack references on one handle: dup2 of slot 0 onto slots 3 to 22 in turn.
    for (int k = 0; k < 60; k++)
      pending_reqs.push_back(make_req(rht_pkg::CMD_DUP2, 2, 0, 3 + (k % 20), 0));
    for (int k = 0; k < 300; k++) pending_reqs.push_back(random_req());
    wait (pending_reqs.size() < 100);
    idle_enable = 1'b0;
    wait (pending_reqs.size() == 0);
    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- refcounted_handle_table.f -----
rtl/rht_pkg.sv
rtl/rht_ram.sv
rtl/rht_find.sv
rtl/refcounted_handle_table.sv
bench/refcounted_handle_table_tb.sv
